// ===== hw/rtl/uvfft_pkg.sv =====
// ----------------------------------------------------------------------------
// uvfft_pkg
// Shared types and constants of the fit/fill texture transform unit.
// ----------------------------------------------------------------------------
package uvfft_pkg;

   localparam int OUT_BITS = 30;
   localparam logic [OUT_BITS-1:0] SCALE_MAX = {OUT_BITS{1'b1}};

   localparam logic [2:0] MODE_CENTER  = 3'd0;
   localparam logic [2:0] MODE_TILE    = 3'd1;
   localparam logic [2:0] MODE_STRETCH = 3'd2;
   localparam logic [2:0] MODE_FIT     = 3'd3;

   // sideband that travels with each request through the divider row
   typedef struct packed {
      logic x_unit;
      logic y_unit;
      logic tile;
   } ctrl_type;

endpackage

// ===== hw/rtl/uvfft_prep.sv =====
// ----------------------------------------------------------------------------
// uvfft_prep
// Input stage: cross products, mode decode and divider operand selection.
// ----------------------------------------------------------------------------
module uvfft_prep
   import uvfft_pkg::*;
#(
   parameter int DIM_BITS  = 14,
   parameter int FRAC_BITS = 16,
   parameter int DW        = 2 * DIM_BITS,
   parameter int LW        = DW + FRAC_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  logic [DIM_BITS-1:0] image_width,
   input  logic [DIM_BITS-1:0] image_height,
   input  logic [DIM_BITS-1:0] screen_width,
   input  logic [DIM_BITS-1:0] screen_height,
   input  logic [2:0]          place_mode,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ctrl_type            dn_ctrl,
   output logic [LW-1:0]       dn_dvd  [2],
   output logic [DW-1:0]       dn_den  [2],
   output logic [DW-1:0]       dn_rem  [2],
   output logic [LW-1:0]       dn_quot [2]
);

   logic                valid_ff;
   logic [DIM_BITS-1:0] iw_ff, ih_ff, sw_ff, sh_ff;
   logic [2:0]          mode_ff;
   logic [DW-1:0]       a_ff, b_ff;

   logic          zero_size, ident, x_unit;
   logic [DW-1:0] num [2];

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         iw_ff   <= image_width;
         ih_ff   <= image_height;
         sw_ff   <= screen_width;
         sh_ff   <= screen_height;
         mode_ff <= place_mode;
         a_ff    <= DW'(screen_width) * DW'(image_height);
         b_ff    <= DW'(screen_height) * DW'(image_width);
      end
   end

   always_comb begin
      zero_size = (iw_ff == '0) || (ih_ff == '0) || (sw_ff == '0) || (sh_ff == '0);
      ident     = zero_size || (mode_ff == MODE_STRETCH);
      x_unit    = (mode_ff == MODE_FIT) ? (a_ff <= b_ff) : (a_ff >= b_ff);
      dn_ctrl.tile = (mode_ff == MODE_TILE) && !zero_size;
      num[0]    = '0;
      num[1]    = '0;
      dn_den[0] = DW'(1);
      dn_den[1] = DW'(1);
      if (ident) begin
         dn_ctrl.x_unit = 1'b1;
         dn_ctrl.y_unit = 1'b1;
      end else if (mode_ff == MODE_CENTER || mode_ff == MODE_TILE) begin
         dn_ctrl.x_unit = 1'b0;
         dn_ctrl.y_unit = 1'b0;
         num[0]    = DW'(sw_ff);
         dn_den[0] = DW'(iw_ff);
         num[1]    = DW'(sh_ff);
         dn_den[1] = DW'(ih_ff);
      end else if (x_unit) begin
         dn_ctrl.x_unit = 1'b1;
         dn_ctrl.y_unit = 1'b0;
         num[1]    = b_ff;
         dn_den[1] = a_ff;
      end else begin
         dn_ctrl.x_unit = 1'b0;
         dn_ctrl.y_unit = 1'b1;
         num[0]    = a_ff;
         dn_den[0] = b_ff;
      end
      for (int k = 0; k < 2; k++) begin
         // rounding bias folded into the dividend
         dn_dvd[k]  = {1'b0, num[k], {FRAC_BITS{1'b0}}} + LW'(dn_den[k] >> 1);
         dn_rem[k]  = '0;
         dn_quot[k] = '0;
      end
   end

endmodule

// ===== hw/rtl/uvfft_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvfft_div_cell
// One restoring division step for both axes, one quotient bit per cell.
// ----------------------------------------------------------------------------
module uvfft_div_cell
   import uvfft_pkg::*;
#(
   parameter int DW = 28,
   parameter int LW = 45
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  ctrl_type      up_ctrl,
   input  logic [LW-1:0] up_dvd  [2],
   input  logic [DW-1:0] up_den  [2],
   input  logic [DW-1:0] up_rem  [2],
   input  logic [LW-1:0] up_quot [2],
   output logic          dn_valid,
   input  logic          dn_ready,
   output ctrl_type      dn_ctrl,
   output logic [LW-1:0] dn_dvd  [2],
   output logic [DW-1:0] dn_den  [2],
   output logic [DW-1:0] dn_rem  [2],
   output logic [LW-1:0] dn_quot [2]
);

   logic          valid_ff;
   ctrl_type      ctrl_ff;
   logic [LW-1:0] dvd_ff  [2];
   logic [DW-1:0] den_ff  [2];
   logic [DW-1:0] rem_ff  [2];
   logic [LW-1:0] quot_ff [2];

   logic [DW:0]   trial  [2];
   logic          ge     [2];
   logic [DW-1:0] rem_in [2];

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_ctrl  = ctrl_ff;
   assign dn_dvd   = dvd_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_quot  = quot_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         trial[k]  = {up_rem[k], up_dvd[k][LW-1]};
         ge[k]     = trial[k] >= {1'b0, up_den[k]};
         rem_in[k] = ge[k] ? DW'(trial[k] - {1'b0, up_den[k]}) : trial[k][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         ctrl_ff <= up_ctrl;
         for (int k = 0; k < 2; k++) begin
            dvd_ff[k]  <= {up_dvd[k][LW-2:0], 1'b0};
            den_ff[k]  <= up_den[k];
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= {up_quot[k][LW-2:0], ge[k]};
         end
      end
   end

endmodule

// ===== hw/rtl/uvfft_post.sv =====
// ----------------------------------------------------------------------------
// uvfft_post
// Output stage: saturation, unit axes, offsets and the response register.
// ----------------------------------------------------------------------------
module uvfft_post
   import uvfft_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int LW        = 45
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  ctrl_type                   up_ctrl,
   input  logic [LW-1:0]              up_quot [2],
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_BITS-1:0]        rsp_scale_x,
   output logic [OUT_BITS-1:0]        rsp_scale_y,
   output logic signed [OUT_BITS-1:0] rsp_offset_x,
   output logic signed [OUT_BITS-1:0] rsp_offset_y,
   output logic                       rsp_tile_on
);

   localparam int EW = (LW > OUT_BITS) ? LW : OUT_BITS + 1;
   localparam logic [OUT_BITS-1:0] ONE = OUT_BITS'(1) << FRAC_BITS;

   logic                       valid_ff;
   logic [OUT_BITS-1:0]        scale_ff [2];
   logic signed [OUT_BITS-1:0] offset_ff [2];
   logic                       tile_ff;

   logic [EW-1:0]            ext    [2];
   logic [OUT_BITS-1:0]      scale  [2];
   logic signed [OUT_BITS:0] diff   [2];
   logic                     unit   [2];

   assign up_ready = !valid_ff || rsp_ready;
   assign rsp_valid    = valid_ff;
   assign rsp_scale_x  = scale_ff[0];
   assign rsp_scale_y  = scale_ff[1];
   assign rsp_offset_x = offset_ff[0];
   assign rsp_offset_y = offset_ff[1];
   assign rsp_tile_on  = tile_ff;

   always_comb begin
      unit[0] = up_ctrl.x_unit;
      unit[1] = up_ctrl.y_unit;
      for (int k = 0; k < 2; k++) begin
         ext[k] = EW'(up_quot[k]);
         if (unit[k]) begin
            scale[k] = ONE;
         end else if (ext[k] > EW'(SCALE_MAX)) begin
            scale[k] = SCALE_MAX;
         end else begin
            scale[k] = ext[k][OUT_BITS-1:0];
         end
         diff[k] = $signed({1'b0, ONE}) - $signed({1'b0, scale[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         tile_ff <= up_ctrl.tile;
         for (int k = 0; k < 2; k++) begin
            scale_ff[k] <= scale[k];
            // arithmetic shift gives the floored half
            offset_ff[k] <= up_ctrl.tile ? '0 : OUT_BITS'(diff[k] >>> 1);
         end
      end
   end

endmodule

// ===== hw/rtl/uv_fit_fill_transform_unit.sv =====
// ----------------------------------------------------------------------------
// uv_fit_fill_transform_unit
// Image-on-screen placement as a per-axis texture coordinate scale and offset.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the pipeline is not backed up by a
// held response. One input stage forms the cross products, a row
// of 2*DIM_BITS+FRAC_BITS+1 division cells produces one quotient bit each for
// both axes, and one output stage saturates and forms the offsets. Every
// stage has its own valid bit, so bubbles close up while the response waits.
module uv_fit_fill_transform_unit
   import uvfft_pkg::*;
#(
   parameter int DIM_BITS  = 14,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DIM_BITS-1:0]        req_image_width,
   input  logic [DIM_BITS-1:0]        req_image_height,
   input  logic [DIM_BITS-1:0]        req_screen_width,
   input  logic [DIM_BITS-1:0]        req_screen_height,
   input  logic [2:0]                 req_place_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_BITS-1:0]        rsp_scale_x,
   output logic [OUT_BITS-1:0]        rsp_scale_y,
   output logic signed [OUT_BITS-1:0] rsp_offset_x,
   output logic signed [OUT_BITS-1:0] rsp_offset_y,
   output logic                       rsp_tile_on
);

   localparam int DW = 2 * DIM_BITS;
   localparam int LW = DW + FRAC_BITS + 1;

   logic          lnk_valid [LW+1];
   logic          lnk_ready [LW+1];
   ctrl_type      lnk_ctrl  [LW+1];
   logic [LW-1:0] lnk_dvd   [LW+1][2];
   logic [DW-1:0] lnk_den   [LW+1][2];
   logic [DW-1:0] lnk_rem   [LW+1][2];
   logic [LW-1:0] lnk_quot  [LW+1][2];

   uvfft_prep #(
      .DIM_BITS (DIM_BITS),
      .FRAC_BITS(FRAC_BITS),
      .DW       (DW),
      .LW       (LW)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .image_width  (req_image_width),
      .image_height (req_image_height),
      .screen_width (req_screen_width),
      .screen_height(req_screen_height),
      .place_mode   (req_place_mode),
      .dn_valid     (lnk_valid[0]),
      .dn_ready     (lnk_ready[0]),
      .dn_ctrl      (lnk_ctrl[0]),
      .dn_dvd       (lnk_dvd[0]),
      .dn_den       (lnk_den[0]),
      .dn_rem       (lnk_rem[0]),
      .dn_quot      (lnk_quot[0])
   );

   for (genvar i = 0; i < LW; i++) begin : g_cell
      uvfft_div_cell #(
         .DW(DW),
         .LW(LW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_valid(lnk_valid[i]),
         .up_ready(lnk_ready[i]),
         .up_ctrl (lnk_ctrl[i]),
         .up_dvd  (lnk_dvd[i]),
         .up_den  (lnk_den[i]),
         .up_rem  (lnk_rem[i]),
         .up_quot (lnk_quot[i]),
         .dn_valid(lnk_valid[i+1]),
         .dn_ready(lnk_ready[i+1]),
         .dn_ctrl (lnk_ctrl[i+1]),
         .dn_dvd  (lnk_dvd[i+1]),
         .dn_den  (lnk_den[i+1]),
         .dn_rem  (lnk_rem[i+1]),
         .dn_quot (lnk_quot[i+1])
      );
   end

   uvfft_post #(
      .FRAC_BITS(FRAC_BITS),
      .LW       (LW)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (lnk_valid[LW]),
      .up_ready    (lnk_ready[LW]),
      .up_ctrl     (lnk_ctrl[LW]),
      .up_quot     (lnk_quot[LW]),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_scale_x (rsp_scale_x),
      .rsp_scale_y (rsp_scale_y),
      .rsp_offset_x(rsp_offset_x),
      .rsp_offset_y(rsp_offset_y),
      .rsp_tile_on (rsp_tile_on)
   );

   // a stalled input can only come from a response held at the output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a held response");

   a_tile_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tile_on) |-> (rsp_offset_x == '0 && rsp_offset_y == '0))
      else $error("tile response with nonzero offset");

   a_offset_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tile_on && rsp_scale_x > (OUT_BITS'(1) << FRAC_BITS))
      |-> rsp_offset_x[OUT_BITS-1])
      else $error("upscaled axis with nonnegative offset");

endmodule

// ===== sim/uvfft_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uvfft_checker
// Watches both channels of the transform unit, predicts each response from
// its request and compares field by field in order of arrival.
// ----------------------------------------------------------------------------
module uvfft_checker
   import uvfft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [13:0]                req_image_width,
   input  logic [13:0]                req_image_height,
   input  logic [13:0]                req_screen_width,
   input  logic [13:0]                req_screen_height,
   input  logic [2:0]                 req_place_mode,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [OUT_BITS-1:0]        rsp_scale_x,
   input  logic [OUT_BITS-1:0]        rsp_scale_y,
   input  logic signed [OUT_BITS-1:0] rsp_offset_x,
   input  logic signed [OUT_BITS-1:0] rsp_offset_y,
   input  logic                       rsp_tile_on,
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count
);

   localparam int FRAC = 16;
   localparam longint ONE_Q = longint'(1) << FRAC;

   typedef struct packed {
      logic [OUT_BITS-1:0] scale_x;
      logic [OUT_BITS-1:0] scale_y;
      logic [OUT_BITS-1:0] offset_x;
      logic [OUT_BITS-1:0] offset_y;
      logic                tile_on;
   } placement_type;

   placement_type placements_due[$];

   function automatic longint rounded_ratio(longint num, longint den);
      longint q;
      q = ((num << FRAC) + (den >>> 1)) / den;
      return (q > longint'(SCALE_MAX)) ? longint'(SCALE_MAX) : q;
   endfunction

   // floor of half the difference, also for negative values
   function automatic logic [OUT_BITS-1:0] centre_offset(longint s);
      longint d;
      longint h;
      d = ONE_Q - s;
      if (d >= 0) begin
         h = d / 2;
      end else begin
         h = -((-d + 1) / 2);
      end
      return h[OUT_BITS-1:0];
   endfunction

   function automatic placement_type place(longint iw, longint ih, longint sw, longint sh,
                                           logic [2:0] mode);
      placement_type p;
      longint sx, sy, a, b;
      logic x_unit;
      sx = ONE_Q;
      sy = ONE_Q;
      p = '0;
      if (iw != 0 && ih != 0 && sw != 0 && sh != 0 && mode != MODE_STRETCH) begin
         if (mode == MODE_TILE || mode == MODE_CENTER) begin
            sx = rounded_ratio(sw, iw);
            sy = rounded_ratio(sh, ih);
            p.tile_on = (mode == MODE_TILE);
         end else begin
            a = sw * ih;
            b = sh * iw;
            x_unit = (mode == MODE_FIT) ? (a <= b) : (a >= b);
            if (x_unit) begin
               sy = rounded_ratio(b, a);
            end else begin
               sx = rounded_ratio(a, b);
            end
         end
         if (mode != MODE_TILE) begin
            p.offset_x = centre_offset(sx);
            p.offset_y = centre_offset(sy);
         end
      end
      p.scale_x = sx[OUT_BITS-1:0];
      p.scale_y = sy[OUT_BITS-1:0];
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      checked_count = 0;
   end

   assign pending_count = placements_due.size();

   always @(posedge clock) begin
      placement_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            placements_due.push_back(place(req_image_width, req_image_height,
                                           req_screen_width, req_screen_height,
                                           req_place_mode));
         end
         if (rsp_valid && rsp_ready) begin
            if (placements_due.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = placements_due.pop_front();
               checked_count++;
               if (rsp_scale_x !== want.scale_x)
                  report_mismatch("scale_x", rsp_scale_x, want.scale_x);
               if (rsp_scale_y !== want.scale_y)
                  report_mismatch("scale_y", rsp_scale_y, want.scale_y);
               if (rsp_offset_x !== want.offset_x)
                  report_mismatch("offset_x", rsp_offset_x, want.offset_x);
               if (rsp_offset_y !== want.offset_y)
                  report_mismatch("offset_y", rsp_offset_y, want.offset_y);
               if (rsp_tile_on !== want.tile_on)
                  report_mismatch("tile_on", rsp_tile_on, want.tile_on);
            end
         end
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives size and mode requests into the transform unit under varied flow
// control; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import uvfft_pkg::*;

   localparam int LATENCY = 47;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] MODE_FILL = 3'd4;
   localparam logic [2:0] MODE_SPAN = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [13:0] req_image_width = '0;
   logic [13:0] req_image_height = '0;
   logic [13:0] req_screen_width = '0;
   logic [13:0] req_screen_height = '0;
   logic [2:0] req_place_mode = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_BITS-1:0] rsp_scale_x, rsp_scale_y;
   logic signed [OUT_BITS-1:0] rsp_offset_x, rsp_offset_y;
   logic rsp_tile_on;
   int fail_count, pending_count, checked_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int sent_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   uv_fit_fill_transform_unit i_dut (.*);

   uvfft_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid is dropped only while idling or draining, so it gets one update per edge
   task automatic send_request(logic [13:0] iw, logic [13:0] ih, logic [13:0] sw,
                               logic [13:0] sh, logic [2:0] mode);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_image_width <= iw;
      req_image_height <= ih;
      req_screen_width <= sw;
      req_screen_height <= sh;
      req_place_mode <= mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // mostly modest sizes, sometimes any 14-bit value, rarely zero
   function automatic logic [13:0] random_size();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return '0;
      if (pick < 30) return 14'($urandom);
      if (pick < 40) return 14'($urandom_range(8));
      return 14'($urandom_range(4096, 1));
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   initial begin
      logic [2:0] mode;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every mode, extremes, zero sizes, saturation, ties
      for (int m = 0; m < 8; m++) begin
         send_request(14'd1920, 14'd1080, 14'd1280, 14'd1024, 3'(m));
      end
      send_request(14'd1, 14'd1, 14'h3fff, 14'h3fff, MODE_CENTER);
      send_request(14'd1, 14'h3fff, 14'h3fff, 14'd1, MODE_FIT);
      send_request(14'd1, 14'h3fff, 14'h3fff, 14'd1, MODE_FILL);
      send_request(14'h3fff, 14'd1, 14'd1, 14'h3fff, MODE_SPAN);
      send_request(14'h3fff, 14'h3fff, 14'd1, 14'd1, MODE_TILE);
      send_request(14'd0, 14'd100, 14'd100, 14'd100, MODE_CENTER);
      send_request(14'd100, 14'd0, 14'd100, 14'd100, MODE_FIT);
      send_request(14'd100, 14'd100, 14'd0, 14'd100, MODE_TILE);
      send_request(14'd100, 14'd100, 14'd100, 14'd0, MODE_FILL);
      send_request(14'd3, 14'd3, 14'd1, 14'd2, MODE_CENTER);
      send_request(14'd640, 14'd480, 14'd640, 14'd480, MODE_FIT);
      send_request(14'h2aaa, 14'h1555, 14'h1555, 14'h2aaa, 3'd7);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 55 : 18) : 0;
         recv_stall_pct = (phase == 2) ? 55 : ((phase == 3) ? 18 : 0);
         if (phase == 2) hold_off = 300;
         for (int n = 0; n < 160; n++) begin
            mode = 3'($urandom_range(7));
            send_request(random_size(), random_size(), random_size(), random_size(), mode);
         end
         // wait for every response before the next phase
         drain();
      end

      $display("sent %0d requests, %0d responses checked", sent_count, checked_count);
      $display("covered all placement modes, zero sizes, saturation and back-pressure");
      if (fail_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== uv_fit_fill_transform_unit.f =====
hw/rtl/uvfft_pkg.sv
hw/rtl/uvfft_prep.sv
hw/rtl/uvfft_div_cell.sv
hw/rtl/uvfft_post.sv
hw/rtl/uv_fit_fill_transform_unit.sv
sim/uvfft_checker.sv
sim/testbench.sv
